@@ design/url_percent_decoder_path_check_assert.svh @@
// ----------------------------------------------------------------------------
// URL percent decoder assertion macros
// Concurrent assertion shorthands shared by the decoder RTL. Define ASSERT_OFF
// to compile them away.
// ----------------------------------------------------------------------------
`ifndef URL_PERCENT_DECODER_PATH_CHECK_ASSERT_SVH
`define URL_PERCENT_DECODER_PATH_CHECK_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, checked on every rising edge outside reset.
`define URLPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define URLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`else

`define URLPD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define URLPD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

@@ design/urlpd_pkg.sv @@
// ----------------------------------------------------------------------------
// URL percent decoder package
// Character codes, decode state and result types and a hex digit helper for the
// decoder step logic; the top level shares the types and the reset state.
// ----------------------------------------------------------------------------
package urlpd_pkg;

	// Characters the decoder reacts to.
	localparam logic [7:0] CH_PERCENT  = 8'h25;
	localparam logic [7:0] CH_PLUS     = 8'h2B;
	localparam logic [7:0] CH_QUESTION = 8'h3F;
	localparam logic [7:0] CH_SPACE    = 8'h20;
	localparam logic [7:0] CH_SLASH    = 8'h2F;
	localparam logic [7:0] CH_DOT      = 8'h2E;

	// Escape sequence phase.
	typedef enum logic [1:0] {
		PH_NORMAL = 2'd0,
		PH_HI     = 2'd1,
		PH_LO     = 2'd2
	} esc_phase_t;

	// Decoder state carried from one byte to the next.
	typedef struct packed {
		esc_phase_t phase;
		logic [3:0] hi_nibble;
		logic       query_mode;
		logic       decode_error;
		logic       path_nonempty;
		logic       path_first_bad;
		logic       previous_dot;
		logic       dotdot_seen;
	} dec_state_t;

	localparam dec_state_t ST_RESET = '{
		phase:          PH_NORMAL,
		hi_nibble:      4'h0,
		query_mode:     1'b0,
		decode_error:   1'b0,
		path_nonempty:  1'b0,
		path_first_bad: 1'b0,
		previous_dot:   1'b0,
		dotdot_seen:    1'b0
	};

	// One result item.
	typedef struct packed {
		logic [7:0] decoded_byte;
		logic       decoded_valid;
		logic       in_query;
		logic       uri_done;
		logic       verdict;
	} dec_result_t;

	// Returns {is_hex, digit value} for an ASCII byte.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [7:0] d;
		logic       ok;
		d  = 8'h00;
		ok = 1'b0;
		if (c inside {[8'h30:8'h39]}) begin
			d  = c - 8'h30;
			ok = 1'b1;
		end else if (c inside {[8'h41:8'h46]}) begin
			d  = c - 8'h37;
			ok = 1'b1;
		end else if (c inside {[8'h61:8'h66]}) begin
			d  = c - 8'h57;
			ok = 1'b1;
		end
		return {ok, d[3:0]};
	endfunction

endpackage

@@ design/urlpd_step.sv @@
// ----------------------------------------------------------------------------
// URL percent decoder step
// Combinational update for one input item: decodes the byte, tracks the path
// checks, forms the verdict on the end item and returns the next state.
// ----------------------------------------------------------------------------
module urlpd_step
	import urlpd_pkg::*;
(
	input  dec_state_t  cur,
	input  logic [7:0]  uri_byte,
	input  logic        byte_present,
	input  logic        end_of_uri,
	output dec_state_t  nxt,
	output dec_result_t res
);

	logic [4:0] hex;
	logic       emit;
	logic [7:0] dec_b;
	logic       q_bit;
	logic       bad;

	assign hex = hex_digit(uri_byte);

	// Byte decode and state update.
	always_comb begin
		nxt   = cur;
		emit  = 1'b0;
		dec_b = 8'h00;
		if (byte_present) begin
			case (cur.phase)
				PH_HI, PH_LO: begin
					if (!hex[4]) begin
						nxt.decode_error = 1'b1;
						nxt.phase        = PH_NORMAL;
					end else if (cur.phase == PH_HI) begin
						nxt.hi_nibble = hex[3:0];
						nxt.phase     = PH_LO;
					end else begin
						dec_b     = {cur.hi_nibble, hex[3:0]};
						emit      = 1'b1;
						nxt.phase = PH_NORMAL;
					end
				end
				default: begin
					// An unreachable phase code behaves like the normal phase.
					nxt.phase = PH_NORMAL;
					if (uri_byte == CH_PERCENT) begin
						nxt.phase = PH_HI;
					end else if (uri_byte == CH_PLUS) begin
						dec_b = CH_SPACE;
						emit  = 1'b1;
					end else if (uri_byte == CH_QUESTION) begin
						nxt.query_mode = 1'b1;
					end else begin
						dec_b = uri_byte;
						emit  = 1'b1;
					end
				end
			endcase
		end

		// Path checks only see bytes decoded before the query part.
		q_bit = nxt.query_mode;
		if (emit && !nxt.query_mode) begin
			if (!cur.path_nonempty) begin
				nxt.path_first_bad = (dec_b != CH_SLASH);
			end
			nxt.path_nonempty = 1'b1;
			if (dec_b == CH_DOT && cur.previous_dot) begin
				nxt.dotdot_seen = 1'b1;
			end
			nxt.previous_dot = (dec_b == CH_DOT);
		end

		bad = nxt.decode_error || (nxt.phase != PH_NORMAL) || !nxt.path_nonempty ||
			nxt.path_first_bad || nxt.dotdot_seen;

		// The end item closes the URI and clears all state.
		if (end_of_uri) begin
			nxt = ST_RESET;
		end
	end

	// Result item.
	always_comb begin
		res.decoded_byte  = emit ? dec_b : 8'h00;
		res.decoded_valid = emit;
		res.in_query      = emit & q_bit;
		res.uri_done      = end_of_uri;
		res.verdict       = end_of_uri & bad;
	end

endmodule

@@ design/url_percent_decoder_path_check.sv @@
// ----------------------------------------------------------------------------
// URL percent decoder with path check
// Streams a request URI one byte per transaction, decodes escapes and '+',
// splits path from query at the first '?', and flags bad requests.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle while the output side is not
// stalled, and gives exactly one result transaction for each. Each item passes
// from the input register through the decode step into the output register,
// which presents the result. The combinational decode step between the two
// registers also updates the decode state.
// A stall on the output side holds the output register; the input register then
// keeps one more transaction before ready drops.
// ----------------------------------------------------------------------------
module url_percent_decoder_path_check
	import urlpd_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,

	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [7:0] uri_byte
	input  logic       s_tlast,   // end_of_uri
	input  logic       s_tuser,   // [0] byte_present

	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [7:0] decoded_byte
	output logic       m_tlast,   // uri_done
	output logic [2:0] m_tuser    // [0] decoded_valid, [1] in_query, [2] verdict
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	logic        present_s1;
	logic        last_s1;

	logic        valid_s2;
	dec_result_t res_s2;

	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res_nxt;

	logic        adv_s2;
	logic        adv_s1;

	// Handshake: the output register takes a new item when empty or drained.
	assign adv_s2   = !valid_s2 || m_tready;
	assign adv_s1   = valid_s1 && adv_s2;
	assign s_tready = !valid_s1 || adv_s2;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			byte_s1    <= s_tdata;
			present_s1 <= s_tuser;
			last_s1    <= s_tlast;
		end
	end

	// Decode step.
	urlpd_step u_step (
		.cur          (state_q),
		.uri_byte     (byte_s1),
		.byte_present (present_s1),
		.end_of_uri   (last_s1),
		.nxt          (state_nxt),
		.res          (res_nxt)
	);

	// Decode state advances as each item moves into the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_RESET;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = res_s2.decoded_byte;
	assign m_tlast  = res_s2.uri_done;
	assign m_tuser  = {res_s2.verdict, res_s2.in_query, res_s2.decoded_valid};

	// Checks on the decoder's own logic.
	`include "url_percent_decoder_path_check_assert.svh"

	`URLPD_ASSERT_IMPL(a_verdict_on_end, clk, arst_n, m_tvalid && m_tuser[2], m_tlast, "verdict outside end item")
	`URLPD_ASSERT_IMPL(a_query_with_byte, clk, arst_n, m_tvalid && m_tuser[1], m_tuser[0], "in_query without a byte")
	`URLPD_ASSERT_NEXT(a_state_cleared, clk, arst_n, adv_s1 && last_s1, state_q == ST_RESET, "state not cleared after end item")

endmodule

@@ sim/tb.sv @@
// ----------------------------------------------------------------------------
// Testbench for the URL percent decoder with path check
// Sends request URIs into the stream input one byte per transaction. It starts
// with hand-picked URIs for the corner cases and then sends random URIs, most of
// them well formed. A scoreboard class predicts every result transaction from
// its own decoder state and compares each output field. Both stream sides idle
// at random, except in the closing stretch.
// ----------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import urlpd_pkg::*;

	// One raw URI byte as it goes onto the input stream.
	typedef struct {
		logic [7:0] data;
		logic       present;
		logic       is_last;
	} uri_item_t;

	// Predicts the decoder output and holds the results still to come.
	class decode_scoreboard;
		esc_phase_t  phase;
		logic [3:0]  hi;
		logic        query;
		logic        err;
		logic        nonempty;
		logic        first_bad;
		logic        prev_dot;
		logic        dotdot;
		dec_result_t decoded_expected[$];
		int          n_checked;
		int          n_errors;
		int          n_uris;
		int          n_bad;

		function new();
			clear_state();
			n_checked = 0;
			n_errors  = 0;
			n_uris    = 0;
			n_bad     = 0;
		endfunction

		function void clear_state();
			phase     = PH_NORMAL;
			hi        = 4'h0;
			query     = 1'b0;
			err       = 1'b0;
			nonempty  = 1'b0;
			first_bad = 1'b0;
			prev_dot  = 1'b0;
			dotdot    = 1'b0;
		endfunction

		// Returns {is a hex digit, digit value}.
		function logic [4:0] hex_of(logic [7:0] c);
			if (c >= "0" && c <= "9")
				return {1'b1, 4'(c - "0")};
			if (c >= "A" && c <= "F")
				return {1'b1, 4'(c - "A" + 8'd10)};
			if (c >= "a" && c <= "f")
				return {1'b1, 4'(c - "a" + 8'd10)};
			return 5'h00;
		endfunction

		function int pending();
			return decoded_expected.size();
		endfunction

		// Works out the result of one accepted input transaction.
		function void accept_uri_byte(logic [7:0] c, logic present, logic is_last);
			dec_result_t r;
			logic [4:0]  h;
			logic        emit;
			logic [7:0]  b;
			r    = '0;
			emit = 1'b0;
			b    = 8'h00;
			if (present) begin
				if (phase == PH_HI || phase == PH_LO) begin
					h = hex_of(c);
					if (!h[4]) begin
						// A non-hex byte inside an escape is swallowed.
						err   = 1'b1;
						phase = PH_NORMAL;
					end else if (phase == PH_HI) begin
						hi    = h[3:0];
						phase = PH_LO;
					end else begin
						b     = {hi, h[3:0]};
						emit  = 1'b1;
						phase = PH_NORMAL;
					end
				end else begin
					phase = PH_NORMAL;
					if (c == CH_PERCENT) begin
						phase = PH_HI;
					end else if (c == CH_PLUS) begin
						b    = CH_SPACE;
						emit = 1'b1;
					end else if (c == CH_QUESTION) begin
						query = 1'b1;
					end else begin
						b    = c;
						emit = 1'b1;
					end
				end
				if (emit) begin
					r.decoded_byte  = b;
					r.decoded_valid = 1'b1;
					r.in_query      = query;
					// Only path bytes feed the path checks.
					if (!query) begin
						if (!nonempty)
							first_bad = (b != CH_SLASH);
						nonempty = 1'b1;
						if (b == CH_DOT && prev_dot)
							dotdot = 1'b1;
						prev_dot = (b == CH_DOT);
					end
				end
			end
			if (is_last) begin
				r.uri_done = 1'b1;
				r.verdict  = err || phase != PH_NORMAL || !nonempty || first_bad || dotdot;
				n_uris++;
				if (r.verdict)
					n_bad++;
				clear_state();
			end
			decoded_expected.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				if (n_errors < 30)
					$display("%0t ns: mismatch on %s, expected %h, actual %h",
						$time, name, want, got);
				n_errors++;
			end
		endfunction

		// Compares one output transaction with the oldest prediction.
		function void check_decoded(logic [7:0] data, logic [2:0] user, logic done);
			dec_result_t want;
			n_checked++;
			if (decoded_expected.size() == 0) begin
				$display("%0t ns: unexpected result, expected none, actual data %h user %b last %b",
					$time, data, user, done);
				n_errors++;
				return;
			end
			want = decoded_expected.pop_front();
			compare_field("decoded_byte", want.decoded_byte, data);
			compare_field("decoded_valid", 8'(want.decoded_valid), 8'(user[0]));
			compare_field("in_query", 8'(want.in_query), 8'(user[1]));
			compare_field("uri_done", 8'(want.uri_done), 8'(done));
			compare_field("verdict", 8'(want.verdict), 8'(user[2]));
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       s_tvalid;
	logic       s_tready;
	logic [7:0] s_tdata;
	logic       s_tlast;
	logic       s_tuser;
	logic       m_tvalid;
	logic       m_tready;
	logic [7:0] m_tdata;
	logic       m_tlast;
	logic [2:0] m_tuser;

	decode_scoreboard sb = new();
	uri_item_t        uri_items[$];
	bit               quiet = 1'b0;
	int               n_sent = 0;

	url_percent_decoder_path_check dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always #5 clk = ~clk;

	// Output side: check each transaction and stall in short random bursts.
	initial begin : result_side
		int stall_left;
		stall_left = 0;
		m_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready)
				sb.check_decoded(m_tdata, m_tuser, m_tlast);
			if (stall_left > 0) begin
				m_tready <= 1'b0;
				stall_left--;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				m_tready <= 1'b0;
				stall_left = $urandom_range(1, 3) - 1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	function automatic logic [7:0] hex_char(logic [3:0] n, bit upper);
		if (n < 4'd10)
			return 8'h30 + 8'(n);
		return (upper ? 8'h41 : 8'h61) + 8'(n) - 8'd10;
	endfunction

	function automatic void add_item(logic [7:0] data, logic present);
		uri_item_t it;
		it.data    = data;
		it.present = present;
		it.is_last = 1'b0;
		uri_items.push_back(it);
	endfunction

	function automatic void add_text(string s);
		for (int i = 0; i < s.len(); i++)
			add_item(s[i], 1'b1);
	endfunction

	// Sends the queued URI; the end mark goes on its own byteless item if asked.
	task automatic send_uri(bit end_without_byte);
		uri_item_t it;
		if (end_without_byte || uri_items.size() == 0)
			add_item(8'($urandom_range(0, 255)), 1'b0);
		uri_items[uri_items.size() - 1].is_last = 1'b1;
		while (uri_items.size() != 0) begin
			it = uri_items.pop_front();
			if (!quiet && $urandom_range(0, 5) == 0) begin
				s_tvalid <= 1'b0;
				repeat ($urandom_range(1, 3)) @(posedge clk);
			end
			s_tvalid <= 1'b1;
			s_tdata  <= it.data;
			s_tuser  <= it.present;
			s_tlast  <= it.is_last;
			@(posedge clk);
			while (!s_tready)
				@(posedge clk);
			sb.accept_uri_byte(it.data, it.present, it.is_last);
			n_sent++;
		end
	endtask

	// Stops sending and waits until every predicted result has come out.
	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	// Builds a random URI, well formed most of the time.
	function automatic void build_random_uri();
		string      alpha;
		bit         well;
		int         ntok;
		int         kind;
		logic [7:0] v;
		alpha = "/.abcxz09-_~=&";
		well  = ($urandom_range(0, 9) < 8);
		if (well ? ($urandom_range(0, 9) != 0) : ($urandom_range(0, 1) == 0))
			add_item(CH_SLASH, 1'b1);
		ntok = $urandom_range(0, 10);
		for (int i = 0; i < ntok; i++) begin
			kind = $urandom_range(0, 99);
			if (kind < 40) begin
				add_item(alpha[$urandom_range(0, alpha.len() - 1)], 1'b1);
			end else if (kind < 48) begin
				add_item(CH_DOT, 1'b1);
			end else if (kind < 55) begin
				add_item(CH_PLUS, 1'b1);
			end else if (kind < 61) begin
				add_item(CH_QUESTION, 1'b1);
			end else if (kind < 78) begin
				// Escaped byte, sometimes an encoded dot or slash.
				case ($urandom_range(0, 3))
					0: v = CH_DOT;
					1: v = CH_SLASH;
					default: v = 8'($urandom_range(0, 255));
				endcase
				add_item(CH_PERCENT, 1'b1);
				add_item(hex_char(v[7:4], 1'($urandom_range(0, 1))), 1'b1);
				add_item(hex_char(v[3:0], 1'($urandom_range(0, 1))), 1'b1);
			end else if (kind < 85) begin
				add_item(8'($urandom_range(0, 255)), 1'b0);
			end else if (kind < 93 || !well) begin
				add_item(8'($urandom_range(0, 255)), 1'b1);
			end else begin
				// Broken escape: a stray byte in one of the digit places, or cut short.
				add_item(CH_PERCENT, 1'b1);
				if ($urandom_range(0, 1) == 0)
					add_item(hex_char(4'($urandom_range(0, 15)), 1'b0), 1'b1);
				if (i != ntok - 1 || $urandom_range(0, 1) == 0)
					add_item("g" + 8'($urandom_range(0, 19)), 1'b1);
			end
		end
	endfunction

	// Stimulus: reset, directed URIs, then random URIs.
	initial begin : stimulus
		arst_n   = 1'b0;
		s_tvalid <= 1'b0;
		s_tdata  <= 8'h00;
		s_tuser  <= 1'b0;
		s_tlast  <= 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Escape with a lowercase hex digit, then a non-hex digit inside an escape.
		add_text("/%4a?%zq");
		send_uri(1'b0);
		// Extreme byte values, a byteless item mid-URI, byteless end item.
		add_item(8'hFF, 1'b1);
		add_item(8'h5A, 1'b0);
		add_item(8'h00, 1'b1);
		send_uri(1'b1);
		// Empty URI.
		send_uri(1'b1);
		// Dot-dot in the path.
		add_text("/..");
		send_uri(1'b0);
		// Escape cut short by the end of the URI.
		add_text("/%A");
		send_uri(1'b0);
		// Query only, so the path is empty.
		add_text("?x");
		send_uri(1'b0);
		// Clean URI with an encoded slash and a plus in the query.
		add_text("/%2F?+");
		send_uri(1'b1);
		wait_drained();

		while (n_sent < 1800) begin
			if (n_sent >= 1500)
				quiet = 1'b1;
			build_random_uri();
			send_uri($urandom_range(0, 3) == 0);
			// Hold the sender mid-run until the output has caught up.
			if (n_sent >= 900 && n_sent < 915)
				wait_drained();
		end
		wait_drained();
		repeat (20) @(posedge clk);

		$display("Covered %0d URIs (%0d with a bad verdict), %0d input transactions,",
			sb.n_uris, sb.n_bad, n_sent);
		$display("and %0d result transactions checked with random idling on both sides.",
			sb.n_checked);
		if (sb.n_errors == 0 && sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin : watchdog
		#2000000;
		$display("Timeout with %0d results outstanding", sb.pending());
		$display("Simulation FAILED");
		$finish;
	end

endmodule
